// ----- rtl/ssm_pkg.sv -----
// ssm_pkg: shared types and op codes for the sorted sequence merge unit
// no dependencies; imported by the interfaces, the store and the top level
`timescale 1ns / 1ps
`default_nettype none

package ssm_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [1:0]               t_op;

    // request op codes
    localparam t_op OP_APPEND_FIRST  = 2'd0;
    localparam t_op OP_APPEND_SECOND = 2'd1;
    localparam t_op OP_MERGE         = 2'd2;

endpackage

`default_nettype wire

// ----- rtl/ssm_if.sv -----
// ssm_in_if / ssm_out_if: valid-ready channels for requests and merged results
// depends on ssm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ssm_in_if;
    logic          valid;
    logic          ready;
    ssm_pkg::t_op  op;
    ssm_pkg::t_data value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface ssm_out_if;
    logic           valid;
    logic           ready;
    ssm_pkg::t_data merged_value;
    logic           from_second;
    logic           last;
    logic           overflow;

    modport source (output valid, output merged_value, output from_second,
                    output last, output overflow, input ready);
    modport sink   (input valid, input merged_value, input from_second,
                    input last, input overflow, output ready);
endinterface

`default_nettype wire

// ----- rtl/ssm_store.sv -----
// ssm_store: one element store, single write port, registered read port
// depends on ssm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssm_store #(
    parameter int  DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire ssm_pkg::t_data  i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output ssm_pkg::t_data       o_rdata
);
    import ssm_pkg::*;

    t_data r_mem [DEPTH];
    t_data r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/sorted_sequence_merge_unit.sv -----
// sorted_sequence_merge_unit: top level, two element stores and the merge sequencer
// depends on ssm_pkg, ssm_if and ssm_store
`timescale 1ns / 1ps
`default_nettype none

// Collects two sequences of signed 32-bit values and merges them on request.
// An append request (op 0 to the first store, op 1 to the second) is taken
// while the unit is idle and gives no result; appends beyond DEPTH are dropped
// and set a sticky overflow flag that rides on every result of the next merge.
// A merge request (op 2) emits every stored element, one result each, taking
// the head of the first store when it is strictly smaller, otherwise the head
// of the second, and the rest of one store once the other is used up; the
// final result carries last, and both stores are then empty and the flag is
// cleared. Each element passes through a registered store read, then the
// shared compare and the output load, which waits while the output side
// stalls; the input is not ready until the last result is loaded. A merge
// of two empty stores emits nothing. Op 3 is accepted and ignored. The result
// register lets new append requests be taken while the final result waits.
module sorted_sequence_merge_unit #(
    parameter int DEPTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ssm_in_if.sink     i_in,
    ssm_out_if.source  o_out
);
    import ssm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_cnt_a, n_cnt_a;
    logic [CW-1:0] r_cnt_b, n_cnt_b;
    logic [CW-1:0] r_ia, n_ia;
    logic [CW-1:0] r_ib, n_ib;
    logic          r_drop, n_drop;

    logic          r_out_valid, n_out_valid;
    t_data         r_out_value, n_out_value;
    logic          r_out_second, n_out_second;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          in_fire;
    logic          slot_free;
    logic          we_a, we_b;
    t_data         head_a, head_b;
    logic          a_left, b_left, take_a, is_last;
    logic [CW:0]   done_cnt, total_cnt;

    assign in_fire   = i_in.valid && i_in.ready;
    assign slot_free = !r_out_valid || o_out.ready;

    assign we_a = in_fire && (i_in.op == OP_APPEND_FIRST)  && (r_cnt_a < CW'(DEPTH));
    assign we_b = in_fire && (i_in.op == OP_APPEND_SECOND) && (r_cnt_b < CW'(DEPTH));

    // element stores
    ssm_store #(.DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_ia[AW-1:0]),
        .o_rdata (head_a)
    );

    ssm_store #(.DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (i_in.value),
        .i_raddr (r_ib[AW-1:0]),
        .o_rdata (head_b)
    );

    // shared compare and merge position
    assign a_left    = r_ia < r_cnt_a;
    assign b_left    = r_ib < r_cnt_b;
    assign take_a    = a_left && (!b_left || (head_a < head_b));
    assign done_cnt  = (CW+1)'(r_ia) + (CW+1)'(r_ib) + (CW+1)'(1);
    assign total_cnt = (CW+1)'(r_cnt_a) + (CW+1)'(r_cnt_b);
    assign is_last   = done_cnt == total_cnt;

    // sequencer next state
    always_comb begin
        n_state      = r_state;
        n_cnt_a      = r_cnt_a;
        n_cnt_b      = r_cnt_b;
        n_ia         = r_ia;
        n_ib         = r_ib;
        n_drop       = r_drop;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_second = r_out_second;
        n_out_last   = r_out_last;
        n_out_ovf    = r_out_ovf;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.op)
                        OP_APPEND_FIRST: begin
                            if (we_a) n_cnt_a = r_cnt_a + CW'(1);
                            else      n_drop  = 1'b1;
                        end
                        OP_APPEND_SECOND: begin
                            if (we_b) n_cnt_b = r_cnt_b + CW'(1);
                            else      n_drop  = 1'b1;
                        end
                        OP_MERGE: begin
                            n_ia = '0;
                            n_ib = '0;
                            if (total_cnt == '0) n_drop  = 1'b0;
                            else                 n_state = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_FETCH: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = take_a ? head_a : head_b;
                    n_out_second = !take_a;
                    n_out_last   = is_last;
                    n_out_ovf    = r_drop;
                    if (take_a) n_ia = r_ia + CW'(1);
                    else        n_ib = r_ib + CW'(1);
                    if (is_last) begin
                        n_cnt_a = '0;
                        n_cnt_b = '0;
                        n_drop  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_FETCH;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt_a     <= n_cnt_a;
            r_cnt_b     <= n_cnt_b;
            r_ia        <= n_ia;
            r_ib        <= n_ib;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_second <= n_out_second;
        r_out_last   <= n_out_last;
        r_out_ovf    <= n_out_ovf;
    end

    assign i_in.ready         = r_state == ST_IDLE;
    assign o_out.valid        = r_out_valid;
    assign o_out.merged_value = r_out_value;
    assign o_out.from_second  = r_out_second;
    assign o_out.last         = r_out_last;
    assign o_out.overflow     = r_out_ovf;

endmodule

`default_nettype wire

// ----- rtl/ssm_checker.sv -----
// ssm_checker: port-level assertions for the merge unit, bound to the top level
// depends on ssm_pkg and sorted_sequence_merge_unit
`timescale 1ns / 1ps
`default_nettype none

module ssm_checker (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    input wire logic  i_in_ready,
    input wire logic  i_out_valid,
    input wire logic  i_out_ready,
    input wire logic  i_out_last,
    input wire logic  i_out_second,
    input wire logic  i_out_ovf,
    input wire ssm_pkg::t_data i_out_value
);
    import ssm_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_out_value) && $stable(i_out_last) &&
            $stable(i_out_second) && $stable(i_out_ovf))
        else $error("result payload changed while stalled");

    // no new request is taken in the middle of a merge
    a_busy_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("request taken during a merge");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

endmodule

bind sorted_sequence_merge_unit ssm_checker u_ssm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_last   (o_out.last),
    .i_out_second (o_out.from_second),
    .i_out_ovf    (o_out.overflow),
    .i_out_value  (o_out.merged_value)
);

`default_nettype wire
